// ===== rtl/f2um_pkg.sv =====
package f2um_pkg;

  localparam int unsigned FloatW = 64;
  localparam int unsigned FracW  = 52;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned SigW   = FracW + 1;
  localparam int unsigned ScaleW = 20;
  localparam int unsigned ProdW  = SigW + ScaleW;
  localparam int unsigned ShamtW = 7;
  localparam int unsigned ValueW = 64;

  localparam logic [ScaleW-1:0] Scale       = ScaleW'(1000000);
  localparam logic [ExpW-1:0]   ExpAllOnes  = {ExpW{1'b1}};
  // Raw exponent at which the binary exponent of the integer significand is zero.
  localparam logic [ExpW-1:0]   ExpUnity    = ExpW'(1075);
  localparam logic [ExpW-1:0]   SubnormShr  = ExpW'(1074);
  // Any right shift of at least this amount leaves nothing, round bit included.
  localparam logic [ExpW-1:0]   ShrLimit    = ExpW'(75);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONFINITE = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    logic             neg;
    status_e          status;
    logic [ShamtW-1:0] shamt;
    logic [ProdW-1:0] prod;
  } dec_t;

  typedef struct packed {
    logic             neg;
    status_e          status;
    logic             inc;
    logic [ProdW-1:0] quot;
  } shr_t;

endpackage

// ===== rtl/f2um_decode.sv =====
module f2um_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [f2um_pkg::FloatW-1:0]   float_bits_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output f2um_pkg::dec_t                data_o
);

  logic                         valid_q;
  f2um_pkg::dec_t               data_q;
  f2um_pkg::dec_t               data_d;
  logic [f2um_pkg::ExpW-1:0]    raw_exp;
  logic [f2um_pkg::FracW-1:0]   frac;
  logic [f2um_pkg::SigW-1:0]    sig;
  logic [f2um_pkg::ExpW-1:0]    shr;

  assign raw_exp = float_bits_i[f2um_pkg::FracW +: f2um_pkg::ExpW];
  assign frac    = float_bits_i[f2um_pkg::FracW-1:0];

  always_comb begin
    sig = {(raw_exp != '0), frac};
    if (raw_exp == '0) begin
      shr = f2um_pkg::SubnormShr;
    end else begin
      shr = f2um_pkg::ExpUnity - raw_exp;
    end
    data_d.neg  = float_bits_i[f2um_pkg::FloatW-1];
    data_d.prod = f2um_pkg::ProdW'({{f2um_pkg::ScaleW{1'b0}}, sig} *
                                   {{f2um_pkg::SigW{1'b0}}, f2um_pkg::Scale});
    if (shr > f2um_pkg::ShrLimit) begin
      data_d.shamt = f2um_pkg::ShamtW'(f2um_pkg::ShrLimit);
    end else begin
      data_d.shamt = shr[f2um_pkg::ShamtW-1:0];
    end
    // A normal value with a non-negative binary exponent is at least 2^71 after
    // scaling, so every left shift is out of range.
    if (raw_exp == f2um_pkg::ExpAllOnes) begin
      data_d.status = f2um_pkg::ST_NONFINITE;
    end else if (raw_exp >= f2um_pkg::ExpUnity) begin
      data_d.status = f2um_pkg::ST_RANGE;
    end else begin
      data_d.status = f2um_pkg::ST_OK;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/f2um_shift.sv =====
module f2um_shift (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  f2um_pkg::dec_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output f2um_pkg::shr_t   data_o
);

  logic                          valid_q;
  f2um_pkg::shr_t                data_q;
  f2um_pkg::shr_t                data_d;
  logic [f2um_pkg::ShamtW-1:0]   sm1;
  logic [f2um_pkg::ProdW-1:0]    below;
  logic [f2um_pkg::ProdW-1:0]    mask;
  logic                          round_bit;
  logic                          sticky;

  always_comb begin
    // Only out-of-range inputs shift by zero; else the round bit exists.
    sm1        = data_i.shamt - f2um_pkg::ShamtW'(1);
    below      = data_i.prod >> sm1;
    round_bit  = below[0];
    mask       = ~({f2um_pkg::ProdW{1'b1}} << sm1);
    sticky     = |(data_i.prod & mask);
    data_d.quot   = data_i.prod >> data_i.shamt;
    data_d.inc    = round_bit && (sticky || data_d.quot[0]);
    data_d.neg    = data_i.neg;
    data_d.status = data_i.status;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/f2um_round.sv =====
module f2um_round (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  f2um_pkg::shr_t                data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [f2um_pkg::ValueW-1:0]   value_o,
  output f2um_pkg::status_e             status_o
);

  localparam logic [f2um_pkg::ProdW-1:0] MinMag =
    f2um_pkg::ProdW'(1) << (f2um_pkg::ValueW - 1);

  logic                          valid_q;
  logic [f2um_pkg::ValueW-1:0]   value_q;
  logic [f2um_pkg::ValueW-1:0]   value_d;
  f2um_pkg::status_e             status_q;
  f2um_pkg::status_e             status_d;
  logic [f2um_pkg::ProdW-1:0]    mag;

  always_comb begin
    mag      = data_i.quot + f2um_pkg::ProdW'(data_i.inc);
    value_d  = '0;
    status_d = data_i.status;
    if (data_i.status == f2um_pkg::ST_OK) begin
      // A magnitude of exactly 2^63 fits only as the most negative value.
      if (mag > MinMag || (mag == MinMag && !data_i.neg)) begin
        status_d = f2um_pkg::ST_RANGE;
      end else if (data_i.neg) begin
        value_d = '0 - mag[f2um_pkg::ValueW-1:0];
      end else begin
        value_d = mag[f2um_pkg::ValueW-1:0];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

// ===== rtl/float_to_micrometre_quantizer.sv =====
// Converts the raw bits of a binary64 value into that value times one million,
// rounded to nearest with ties to even, as a signed 64-bit integer. One request
// is taken per clock unless back-pressure from a held result reaches the input.
// Each result passes the decode, shift and round registers in turn. The
// three register stages are decode with the 53 by 20 bit scaling multiply, the
// rounding right shift, and the final increment with range check and negation,
// the last stage being the output register. Back-pressure stalls the stages
// behind a held result only, so bubbles are squeezed out. Status in tuser is 0
// for a good result, 1 for NaN or infinity and 2 for a result outside the signed
// 64-bit range; the value is 0 whenever the status is not 0.
module float_to_micrometre_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] float_bits
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] scaled_value
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  logic               dec_valid;
  logic               dec_ready;
  f2um_pkg::dec_t     dec_data;
  logic               shr_valid;
  logic               shr_ready;
  f2um_pkg::shr_t     shr_data;
  f2um_pkg::status_e  status;

  f2um_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid_i),
    .ready_o      (s_axis_tready_o),
    .float_bits_i (s_axis_tdata_i),
    .valid_o      (dec_valid),
    .ready_i      (dec_ready),
    .data_o       (dec_data)
  );

  f2um_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (shr_valid),
    .ready_i (shr_ready),
    .data_o  (shr_data)
  );

  f2um_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (shr_valid),
    .ready_o  (shr_ready),
    .data_i   (shr_data),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .value_o  (m_axis_tdata_o),
    .status_o (status)
  );

  assign m_axis_tuser_o = status;

  // An error result always carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status != f2um_pkg::ST_OK) |-> (m_axis_tdata_o == '0))
    else $error("error result with non-zero value");

  // An empty output register means no stage can be stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output register empty");

  // A result that is taken while nothing is stalled frees room at the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

endmodule

// ===== sim/f2um_result_monitor.sv =====
`timescale 1ns / 1ps

module f2um_result_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [63:0] req_bits_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [63:0] res_value_i,
  input  logic [1:0]  res_status_i,
  output int          fail_count_o,
  output int          open_count_o
);

  localparam int SubnormalExp = -1074;
  // Bias plus the fraction width: the raw exponent at which the integer
  // significand needs no shift.
  localparam int IntegerExp   = 1075;
  localparam int WideW        = 128;

  typedef struct packed {
    logic [63:0]       value;
    f2um_pkg::status_e status;
  } micrometre_t;

  micrometre_t       pending_micrometres[$];
  micrometre_t       want;
  micrometre_t       fresh;
  logic [63:0]       pred_value;
  f2um_pkg::status_e pred_status;
  int                errors;

  function automatic void scale_to_micrometres(input  logic [63:0]       bits,
                                               output logic [63:0]       value,
                                               output f2um_pkg::status_e status);
    logic [f2um_pkg::ExpW-1:0]   raw_exp;
    logic [f2um_pkg::FracW-1:0]  frac;
    logic [WideW-1:0]            product;
    logic [WideW-1:0]            magnitude;
    logic [WideW-1:0]            below_mask;
    int                          binexp;
    int                          shift;
    logic                        round_bit;
    logic                        sticky;
    raw_exp = bits[62:52];
    frac    = bits[51:0];
    value   = '0;
    status  = f2um_pkg::ST_OK;
    if (raw_exp == f2um_pkg::ExpAllOnes) begin
      status = f2um_pkg::ST_NONFINITE;
      return;
    end
    if (raw_exp == '0 && frac == '0) return;
    if (raw_exp == '0) begin
      product = WideW'(frac) * WideW'(f2um_pkg::Scale);
      binexp  = SubnormalExp;
    end else begin
      product = WideW'({1'b1, frac}) * WideW'(f2um_pkg::Scale);
      binexp  = int'(raw_exp) - IntegerExp;
    end
    if (binexp >= 0) begin
      if (binexp >= WideW) begin
        status = f2um_pkg::ST_RANGE;
        return;
      end
      if (binexp > 0 && (product >> (WideW - binexp)) != '0) begin
        status = f2um_pkg::ST_RANGE;
        return;
      end
      magnitude = product << binexp;
    end else begin
      shift = -binexp;
      // The product stays far below half of 2^128, so the widest shifts leave nothing.
      if (shift >= WideW) begin
        magnitude = '0;
      end else begin
        magnitude  = product >> shift;
        round_bit  = product[shift-1];
        below_mask = (WideW'(1) << (shift - 1)) - WideW'(1);
        sticky     = |(product & below_mask);
        if (round_bit && (sticky || magnitude[0])) magnitude = magnitude + WideW'(1);
      end
    end
    if (magnitude[127:64] != '0 || magnitude[63:0] > {1'b1, 63'b0}) begin
      status = f2um_pkg::ST_RANGE;
      return;
    end
    if (bits[63]) begin
      value = 64'd0 - magnitude[63:0];
    end else if (magnitude[63:0] == {1'b1, 63'b0}) begin
      status = f2um_pkg::ST_RANGE;
    end else begin
      value = magnitude[63:0];
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        scale_to_micrometres(req_bits_i, pred_value, pred_status);
        fresh = '{value: pred_value, status: pred_status};
        pending_micrometres = {pending_micrometres, fresh};
      end
      if (res_valid_i && res_ready_i) begin
        if (pending_micrometres.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result: expected none, actual value %h status %0d",
                   $time, res_value_i, res_status_i);
        end else begin
          want = pending_micrometres.pop_front();
          if (res_value_i !== want.value) begin
            errors = errors + 1;
            $display("%0t: value mismatch: expected %h, actual %h",
                     $time, want.value, res_value_i);
          end
          if (res_status_i !== want.status) begin
            errors = errors + 1;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, res_status_i);
          end
        end
      end
    end
    fail_count_o <= errors;
    open_count_o <= pending_micrometres.size();
  end

endmodule

// ===== sim/tb_float_to_micrometre_quantizer.sv =====
`timescale 1ns / 1ps

module tb_float_to_micrometre_quantizer;

  localparam int RandomFloats = 1150;
  localparam int CycleLimit   = 100000;
  localparam int IdlePercent  = 29;
  localparam int CalmFrom     = 1300;
  localparam int CalmTo       = 1700;
  localparam int HoldAt       = 400;
  localparam int HoldCycles   = 250;
  localparam int DrainCycles  = 12;
  // Fraction of 2^20 / 10^6 scaled to 52 bits: with an exponent of 2^43 this
  // sits right under the signed 64-bit limit once multiplied by one million.
  localparam logic [f2um_pkg::FracW-1:0] EdgeFrac = 52'd218766855499149;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count;
  int          open_count;
  int          cyc;

  float_to_micrometre_quantizer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  f2um_result_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_bits_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_value_i  (m_axis_tdata),
    .res_status_i (m_axis_tuser),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic calm_window(input int c);
    return c >= CalmFrom && c < CalmTo;
  endfunction

  function automatic logic [f2um_pkg::FracW-1:0] random_frac();
    return f2um_pkg::FracW'({$urandom, $urandom});
  endfunction

  // Mostly finite values whose scaled magnitude lands in or near the signed
  // 64-bit range; the rest is raw noise, specials and the extremes of the format.
  function automatic logic [63:0] random_float();
    logic                       sign;
    logic [f2um_pkg::ExpW-1:0]  raw_exp;
    logic [f2um_pkg::FracW-1:0] frac;
    int                         cut;
    sign = 1'($urandom);
    frac = random_frac();
    case ($urandom_range(0, 9))
      0, 1: return {$urandom, $urandom};
      2, 3, 4: raw_exp = f2um_pkg::ExpW'($urandom_range(1023 - 24, 1023 + 44));
      5: begin
        raw_exp = f2um_pkg::ExpW'($urandom_range(1065, 1067));
        if ($urandom_range(0, 1) == 0) begin
          raw_exp = f2um_pkg::ExpW'(1066);
          frac    = EdgeFrac + f2um_pkg::FracW'($urandom_range(0, 2000)) -
                    f2um_pkg::FracW'(1000);
        end
      end
      6: begin
        // Short fractions make exact halves after scaling likely.
        raw_exp = f2um_pkg::ExpW'($urandom_range(1023 - 30, 1023 - 6));
        cut     = $urandom_range(20, 52);
        frac    = frac & ~((f2um_pkg::FracW'(1) << cut) - f2um_pkg::FracW'(1));
      end
      7: begin
        raw_exp = '0;
        if ($urandom_range(0, 1) == 0) frac = f2um_pkg::FracW'($urandom_range(0, 1000));
      end
      8: begin
        case ($urandom_range(0, 3))
          0: raw_exp = f2um_pkg::ExpAllOnes;
          1: begin
            raw_exp = f2um_pkg::ExpAllOnes;
            frac    = '0;
          end
          2: begin
            raw_exp = '0;
            frac    = '0;
          end
          default: raw_exp = f2um_pkg::ExpW'($urandom_range(1068, 2046));
        endcase
      end
      default: raw_exp = f2um_pkg::ExpW'($urandom_range(1, 1000));
    endcase
    return {sign, raw_exp, frac};
  endfunction

  task automatic send_float(input logic [63:0] bits);
    while (!calm_window(cyc) && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc <= cyc + 1;
      if (cyc >= CycleLimit) begin
        $display("[float_to_micrometre_quantizer] ERROR");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, one long hold-off that fills the
  // pipeline, and a calm stretch with the port always ready.
  initial begin
    int rx_cycles;
    int hold_left;
    rx_cycles = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles = rx_cycles + 1;
      if (rx_cycles == HoldAt) hold_left = HoldCycles;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (calm_window(cyc)) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= IdlePercent);
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_float(64'h0000_0000_0000_0000);
    send_float(64'h8000_0000_0000_0000);
    send_float(64'h3FF0_0000_0000_0000);
    send_float(64'hBFF0_0000_0000_0000);
    send_float(64'h0000_0000_0000_0001);
    send_float(64'h800F_FFFF_FFFF_FFFF);
    send_float(64'h0010_0000_0000_0000);
    send_float(64'h7FEF_FFFF_FFFF_FFFF);
    send_float(64'h7FF0_0000_0000_0000);
    send_float(64'hFFF0_0000_0000_0000);
    send_float(64'h7FF8_0000_0000_0000);
    send_float(64'hFFFF_FFFF_FFFF_FFFF);
    // Exact halves after scaling: one rounds down to even, one up.
    send_float(64'h3F80_0000_0000_0000);
    send_float(64'hBF98_0000_0000_0000);
    send_float(64'h3EB0_C6F7_A0B5_ED8D);
    send_float(64'h3EA0_C6F7_A0B5_ED8D);
    send_float(64'h42A0_0000_0000_0000);
    send_float(64'hC2B0_0000_0000_0000);
    send_float({12'h42A, EdgeFrac});
    send_float({12'hC2A, EdgeFrac});
    send_float({12'h42A, EdgeFrac + f2um_pkg::FracW'(1)});
    send_float({12'hC2A, EdgeFrac + f2um_pkg::FracW'(1)});
    send_float(64'h4330_0000_0000_0000);
    send_float(64'h4340_0000_0000_0000);
    send_float(64'h4B30_0000_0000_0000);
    send_float(64'h39B0_0000_0000_0000);

    for (int n = 0; n < RandomFloats; n++) send_float(random_float());
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[float_to_micrometre_quantizer] OK");
    end else begin
      $display("[float_to_micrometre_quantizer] ERROR");
    end
    $finish;
  end

endmodule
